// ===== hdl/assert_macros.svh =====
// ----------------------------------------------------------------------------
// Assertion macros
// Checks on rising clk edges, disabled while rst_n is low.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
`define COA_ASSERT_SAME(label, pre, post) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (pre) |-> (post)) \
        else $error("check failed");
`define COA_ASSERT_NEXT(label, pre, post) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) \
        else $error("check failed");
`else
`define COA_ASSERT_SAME(label, pre, post)
`define COA_ASSERT_NEXT(label, pre, post)
`endif
`endif

// ===== hdl/coa_pkg.sv =====
// ----------------------------------------------------------------------------
// coa_pkg
// Shared constants, types and helpers of the complex overlap accumulator.
// ----------------------------------------------------------------------------
package coa_pkg;

    localparam int SAMPLE_BITS = 16;
    localparam int FRAC_BITS   = 2 * (SAMPLE_BITS - 1);
    localparam int PROD_W      = 2 * SAMPLE_BITS + 1;
    localparam int SCALE_R     = (FRAC_BITS >= 16) ? FRAC_BITS - 16 : 0;
    localparam int SCALE_L     = (FRAC_BITS < 16) ? 16 - FRAC_BITS : 0;
    localparam int PEAK_SHIFT  = 48 - FRAC_BITS;
    localparam int CNT_W       = 8;

    localparam logic [CNT_W-1:0] MUL_LAST  = CNT_W'(5);
    localparam logic [CNT_W-1:0] SQRT_LAST = CNT_W'(64);
    localparam logic [CNT_W-1:0] DIV_LAST  = CNT_W'(129);

    localparam logic [63:0] MAX63 = 64'h7FFF_FFFF_FFFF_FFFF;
    localparam logic [63:0] MIN63 = 64'h8000_0000_0000_0000;
    localparam logic [31:0] MAX32 = 32'hFFFF_FFFF;
    localparam logic [31:0] CELL_VOLUME_RESET = 32'h0001_0000;

    localparam logic ADDR_CELL_VOLUME = 1'b0;

    typedef enum logic [2:0] {
        ST_ACC,
        ST_DRAIN,
        ST_MUL,
        ST_SQRT,
        ST_DIV,
        ST_PUB
    } state_t;

    typedef enum logic [3:0] {
        OP_IDLE,
        OP_MUL_LOAD,
        OP_MUL_STEP,
        OP_MUL_STORE,
        OP_SQRT_INIT,
        OP_SQRT_STEP,
        OP_DIV_INIT,
        OP_DIV_STEP,
        OP_DIV_STORE,
        OP_PUBLISH
    } op_t;

    typedef enum logic [2:0] {
        MJ_RE,
        MJ_IM,
        MJ_N1,
        MJ_N2,
        MJ_SQRE,
        MJ_SQIM,
        MJ_NN
    } mjob_t;

    typedef enum logic [1:0] {
        DJ_OVL,
        DJ_PD1,
        DJ_PD2
    } djob_t;

    typedef struct packed {
        op_t        op;
        logic [1:0] part;
        mjob_t      mjob;
        djob_t      djob;
    } cmd_t;

    function automatic logic [127:0] scale_align(input logic [127:0] p);
        return (p >> SCALE_R) << SCALE_L;
    endfunction

endpackage

// ===== hdl/coa_if.sv =====
// ----------------------------------------------------------------------------
// coa_in_if / coa_out_if
// Valid/ready channels for sample items and result items.
// ----------------------------------------------------------------------------
interface coa_in_if;
    logic        valid;
    logic        ready;
    logic signed [15:0] first_real;
    logic signed [15:0] first_imag;
    logic signed [15:0] second_real;
    logic signed [15:0] second_imag;
    logic        last_point;

    modport source (output valid, first_real, first_imag, second_real, second_imag,
                    last_point, input ready);
    modport sink (input valid, first_real, first_imag, second_real, second_imag,
                  last_point, output ready);
endinterface

interface coa_out_if;
    logic        valid;
    logic        ready;
    logic [62:0] overlap_value;
    logic signed [63:0] inner_real;
    logic signed [63:0] inner_imag;
    logic [62:0] norm_first;
    logic [62:0] norm_second;
    logic [31:0] peak_density_first;
    logic [31:0] peak_density_second;

    modport source (output valid, overlap_value, inner_real, inner_imag, norm_first,
                    norm_second, peak_density_first, peak_density_second, input ready);
    modport sink (input valid, overlap_value, inner_real, inner_imag, norm_first,
                  norm_second, peak_density_first, peak_density_second, output ready);
endinterface

// ===== hdl/coa_ctrl.sv =====
// ----------------------------------------------------------------------------
// coa_ctrl
// Sequencer: accumulate phase, then scale, square root, divide and publish.
// ----------------------------------------------------------------------------
module coa_ctrl (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          in_valid,
    input  logic          in_last,
    output logic          in_ready,
    output logic          out_valid,
    input  logic          out_ready,
    output coa_pkg::cmd_t cmd
);

    coa_pkg::state_t               state_reg, state_next;
    logic [coa_pkg::CNT_W-1:0]     cnt_reg, cnt_next;
    coa_pkg::mjob_t                mjob_reg, mjob_next;
    coa_pkg::djob_t                djob_reg, djob_next;
    logic                          out_valid_reg, out_valid_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= coa_pkg::ST_ACC;
            cnt_reg       <= '0;
            mjob_reg      <= coa_pkg::MJ_RE;
            djob_reg      <= coa_pkg::DJ_OVL;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            cnt_reg       <= cnt_next;
            mjob_reg      <= mjob_next;
            djob_reg      <= djob_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_comb
    begin
        state_next     = state_reg;
        cnt_next       = cnt_reg;
        mjob_next      = mjob_reg;
        djob_next      = djob_reg;
        out_valid_next = out_valid_reg && !out_ready;
        in_ready       = 1'b0;
        cmd.op         = coa_pkg::OP_IDLE;
        cmd.part       = 2'd0;
        cmd.mjob       = mjob_reg;
        cmd.djob       = djob_reg;
        case (state_reg)
            coa_pkg::ST_ACC:
            begin
                in_ready = 1'b1;
                if (in_valid && in_last)
                begin
                    state_next = coa_pkg::ST_DRAIN;
                end
            end
            coa_pkg::ST_DRAIN:
            begin
                state_next = coa_pkg::ST_MUL;
                cnt_next   = '0;
                mjob_next  = coa_pkg::MJ_RE;
            end
            coa_pkg::ST_MUL:
            begin
                cnt_next = cnt_reg + 1'b1;
                if (cnt_reg == '0)
                begin
                    cmd.op = coa_pkg::OP_MUL_LOAD;
                end
                else if (cnt_reg < coa_pkg::MUL_LAST)
                begin
                    cmd.op   = coa_pkg::OP_MUL_STEP;
                    cmd.part = 2'(cnt_reg - 1'b1);
                end
                else
                begin
                    cmd.op   = coa_pkg::OP_MUL_STORE;
                    cnt_next = '0;
                    if (mjob_reg == coa_pkg::MJ_NN)
                    begin
                        state_next = coa_pkg::ST_SQRT;
                    end
                    else
                    begin
                        mjob_next = coa_pkg::mjob_t'(3'(mjob_reg + 3'd1));
                    end
                end
            end
            coa_pkg::ST_SQRT:
            begin
                cnt_next = cnt_reg + 1'b1;
                cmd.op   = (cnt_reg == '0) ? coa_pkg::OP_SQRT_INIT : coa_pkg::OP_SQRT_STEP;
                if (cnt_reg == coa_pkg::SQRT_LAST)
                begin
                    state_next = coa_pkg::ST_DIV;
                    cnt_next   = '0;
                    djob_next  = coa_pkg::DJ_OVL;
                end
            end
            coa_pkg::ST_DIV:
            begin
                cnt_next = cnt_reg + 1'b1;
                if (cnt_reg == '0)
                begin
                    cmd.op = coa_pkg::OP_DIV_INIT;
                end
                else if (cnt_reg < coa_pkg::DIV_LAST)
                begin
                    cmd.op = coa_pkg::OP_DIV_STEP;
                end
                else
                begin
                    cmd.op   = coa_pkg::OP_DIV_STORE;
                    cnt_next = '0;
                    if (djob_reg == coa_pkg::DJ_PD2)
                    begin
                        state_next = coa_pkg::ST_PUB;
                    end
                    else
                    begin
                        djob_next = coa_pkg::djob_t'(2'(djob_reg + 2'd1));
                    end
                end
            end
            coa_pkg::ST_PUB:
            begin
                if (!out_valid_reg || out_ready)
                begin
                    cmd.op         = coa_pkg::OP_PUBLISH;
                    out_valid_next = 1'b1;
                    state_next     = coa_pkg::ST_ACC;
                end
            end
            default:
            begin
                state_next = coa_pkg::ST_ACC;
            end
        endcase
    end

    assign out_valid = out_valid_reg;

endmodule

// ===== hdl/coa_datapath.sv =====
// ----------------------------------------------------------------------------
// coa_datapath
// Accumulators, shared 32x32 multiplier, root and divide units, result regs.
// ----------------------------------------------------------------------------
module coa_datapath (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_fire,
    input  logic signed [15:0] first_real,
    input  logic signed [15:0] first_imag,
    input  logic signed [15:0] second_real,
    input  logic signed [15:0] second_imag,
    input  logic [31:0]        cell_volume,
    input  coa_pkg::cmd_t      cmd,
    output logic [62:0]        overlap_value,
    output logic signed [63:0] inner_real,
    output logic signed [63:0] inner_imag,
    output logic [62:0]        norm_first,
    output logic [62:0]        norm_second,
    output logic [31:0]        peak_density_first,
    output logic [31:0]        peak_density_second
);

    localparam int SB = coa_pkg::SAMPLE_BITS;
    localparam int PW = coa_pkg::PROD_W;

    // stage 1: products
    logic signed [PW-1:0] ax, bx, cx, dx;
    logic                 pv_reg;
    logic signed [PW-1:0] pre_reg, pim_reg;
    logic [PW-1:0]        d1_reg, d2_reg;

    // accumulators
    logic signed [63:0]   sum_re_reg, sum_im_reg;
    logic [63:0]          sum_n1_reg, sum_n2_reg;
    logic [31:0]          pk1_reg, pk2_reg;
    logic signed [64:0]   add_re, add_im;
    logic [64:0]          add_n1, add_n2;
    logic [31:0]          dc1, dc2;

    // multiplier
    logic [63:0]          mul_a_reg, mul_b_reg;
    logic [127:0]         mul_acc_reg;
    logic [31:0]          pa, pb;
    logic [63:0]          mprod;
    logic [127:0]         mterm;
    logic [127:0]         scaled;
    logic [63:0]          slim, sval;
    logic                 neg_reg;

    // intermediate results
    logic [63:0]          rm_reg, imm_reg;
    logic [63:0]          ore_reg, oim_reg;
    logic [62:0]          n1_reg, n2_reg;
    logic [127:0]         r_reg, nn_reg;

    // square root
    logic [127:0]         rad_reg;
    logic [63:0]          root_reg;
    logic [65:0]          srem_reg;
    logic [67:0]          st, strial;

    // divider
    logic [127:0]         num_reg;
    logic [63:0]          den_reg, q_reg;
    logic                 qovf_reg;
    logic [63:0]          drem_reg;
    logic [64:0]          dt, dden;
    logic                 dge;

    // final results
    logic [62:0]          ovl_reg;
    logic [31:0]          pd1_reg, pd2_reg;

    always_comb
    begin
        ax = PW'(signed'(first_real[SB-1:0]));
        bx = PW'(signed'(first_imag[SB-1:0]));
        cx = PW'(signed'(second_real[SB-1:0]));
        dx = PW'(signed'(second_imag[SB-1:0]));

        add_re = 65'(sum_re_reg) + 65'(pre_reg);
        add_im = 65'(sum_im_reg) + 65'(pim_reg);
        add_n1 = {1'b0, sum_n1_reg} + 65'(d1_reg);
        add_n2 = {1'b0, sum_n2_reg} + 65'(d2_reg);
        dc1 = (64'(d1_reg) > 64'(coa_pkg::MAX32)) ? coa_pkg::MAX32 : 32'(d1_reg);
        dc2 = (64'(d2_reg) > 64'(coa_pkg::MAX32)) ? coa_pkg::MAX32 : 32'(d2_reg);

        pa    = cmd.part[1] ? mul_a_reg[63:32] : mul_a_reg[31:0];
        pb    = cmd.part[0] ? mul_b_reg[63:32] : mul_b_reg[31:0];
        mprod = pa * pb;
        case (cmd.part)
            2'd0:    mterm = 128'(mprod);
            2'd3:    mterm = {mprod, 64'd0};
            default: mterm = {32'd0, mprod, 32'd0};
        endcase

        scaled = coa_pkg::scale_align(mul_acc_reg);
        slim   = neg_reg ? coa_pkg::MIN63 : coa_pkg::MAX63;
        if (cmd.mjob == coa_pkg::MJ_N1 || cmd.mjob == coa_pkg::MJ_N2)
        begin
            slim = coa_pkg::MAX63;
        end
        sval = (scaled[127:64] != '0 || scaled[63:0] > slim) ? slim : scaled[63:0];

        st     = {srem_reg, rad_reg[127:126]};
        strial = {2'b00, root_reg, 2'b01};

        dt   = {drem_reg, num_reg[127]};
        dden = {1'b0, den_reg};
        dge  = dt >= dden;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pv_reg     <= 1'b0;
            sum_re_reg <= '0;
            sum_im_reg <= '0;
            sum_n1_reg <= '0;
            sum_n2_reg <= '0;
            pk1_reg    <= '0;
            pk2_reg    <= '0;
        end
        else
        begin
            pv_reg <= in_fire;
            if (cmd.op == coa_pkg::OP_PUBLISH)
            begin
                sum_re_reg <= '0;
                sum_im_reg <= '0;
                sum_n1_reg <= '0;
                sum_n2_reg <= '0;
                pk1_reg    <= '0;
                pk2_reg    <= '0;
            end
            else if (pv_reg)
            begin
                if (add_re[64] != add_re[63])
                begin
                    sum_re_reg <= add_re[64] ? coa_pkg::MIN63 : coa_pkg::MAX63;
                end
                else
                begin
                    sum_re_reg <= add_re[63:0];
                end
                if (add_im[64] != add_im[63])
                begin
                    sum_im_reg <= add_im[64] ? coa_pkg::MIN63 : coa_pkg::MAX63;
                end
                else
                begin
                    sum_im_reg <= add_im[63:0];
                end
                sum_n1_reg <= add_n1[64] ? '1 : add_n1[63:0];
                sum_n2_reg <= add_n2[64] ? '1 : add_n2[63:0];
                if (dc1 > pk1_reg)
                begin
                    pk1_reg <= dc1;
                end
                if (dc2 > pk2_reg)
                begin
                    pk2_reg <= dc2;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_fire)
        begin
            pre_reg <= ax * cx + bx * dx;
            pim_reg <= ax * dx - bx * cx;
            d1_reg  <= PW'(ax * ax + bx * bx);
            d2_reg  <= PW'(cx * cx + dx * dx);
        end
        case (cmd.op)
            coa_pkg::OP_MUL_LOAD:
            begin
                mul_acc_reg <= '0;
                case (cmd.mjob)
                    coa_pkg::MJ_RE:
                    begin
                        mul_a_reg <= sum_re_reg[63] ? 64'd0 - sum_re_reg : sum_re_reg;
                        mul_b_reg <= 64'(cell_volume);
                        neg_reg   <= sum_re_reg[63];
                    end
                    coa_pkg::MJ_IM:
                    begin
                        mul_a_reg <= sum_im_reg[63] ? 64'd0 - sum_im_reg : sum_im_reg;
                        mul_b_reg <= 64'(cell_volume);
                        neg_reg   <= sum_im_reg[63];
                    end
                    coa_pkg::MJ_N1:
                    begin
                        mul_a_reg <= sum_n1_reg;
                        mul_b_reg <= 64'(cell_volume);
                        neg_reg   <= 1'b0;
                    end
                    coa_pkg::MJ_N2:
                    begin
                        mul_a_reg <= sum_n2_reg;
                        mul_b_reg <= 64'(cell_volume);
                        neg_reg   <= 1'b0;
                    end
                    coa_pkg::MJ_SQRE:
                    begin
                        mul_a_reg <= rm_reg;
                        mul_b_reg <= rm_reg;
                        neg_reg   <= 1'b0;
                    end
                    coa_pkg::MJ_SQIM:
                    begin
                        mul_a_reg <= imm_reg;
                        mul_b_reg <= imm_reg;
                        neg_reg   <= 1'b0;
                    end
                    default:
                    begin
                        mul_a_reg <= 64'(n1_reg);
                        mul_b_reg <= 64'(n2_reg);
                        neg_reg   <= 1'b0;
                    end
                endcase
            end
            coa_pkg::OP_MUL_STEP:
            begin
                mul_acc_reg <= mul_acc_reg + mterm;
            end
            coa_pkg::OP_MUL_STORE:
            begin
                case (cmd.mjob)
                    coa_pkg::MJ_RE:
                    begin
                        rm_reg  <= sval;
                        ore_reg <= neg_reg ? 64'd0 - sval : sval;
                    end
                    coa_pkg::MJ_IM:
                    begin
                        imm_reg <= sval;
                        oim_reg <= neg_reg ? 64'd0 - sval : sval;
                    end
                    coa_pkg::MJ_N1:   n1_reg <= sval[62:0];
                    coa_pkg::MJ_N2:   n2_reg <= sval[62:0];
                    coa_pkg::MJ_SQRE: r_reg  <= mul_acc_reg;
                    coa_pkg::MJ_SQIM: r_reg  <= r_reg + mul_acc_reg;
                    default:          nn_reg <= mul_acc_reg;
                endcase
            end
            coa_pkg::OP_SQRT_INIT:
            begin
                rad_reg  <= nn_reg;
                root_reg <= '0;
                srem_reg <= '0;
            end
            coa_pkg::OP_SQRT_STEP:
            begin
                rad_reg <= {rad_reg[125:0], 2'b00};
                if (st >= strial)
                begin
                    srem_reg <= 66'(st - strial);
                    root_reg <= {root_reg[62:0], 1'b1};
                end
                else
                begin
                    srem_reg <= 66'(st);
                    root_reg <= {root_reg[62:0], 1'b0};
                end
            end
            coa_pkg::OP_DIV_INIT:
            begin
                q_reg    <= '0;
                qovf_reg <= 1'b0;
                drem_reg <= '0;
                case (cmd.djob)
                    coa_pkg::DJ_OVL:
                    begin
                        num_reg <= r_reg;
                        den_reg <= root_reg;
                    end
                    coa_pkg::DJ_PD1:
                    begin
                        num_reg <= 128'(pk1_reg) << coa_pkg::PEAK_SHIFT;
                        den_reg <= 64'(n1_reg);
                    end
                    default:
                    begin
                        num_reg <= 128'(pk2_reg) << coa_pkg::PEAK_SHIFT;
                        den_reg <= 64'(n2_reg);
                    end
                endcase
            end
            coa_pkg::OP_DIV_STEP:
            begin
                num_reg  <= {num_reg[126:0], 1'b0};
                qovf_reg <= qovf_reg | q_reg[63];
                q_reg    <= {q_reg[62:0], dge};
                drem_reg <= dge ? 64'(dt - dden) : 64'(dt);
            end
            coa_pkg::OP_DIV_STORE:
            begin
                case (cmd.djob)
                    coa_pkg::DJ_OVL:
                    begin
                        if (den_reg == '0)
                        begin
                            ovl_reg <= (r_reg == '0) ? '0 : coa_pkg::MAX63[62:0];
                        end
                        else if (qovf_reg || q_reg > coa_pkg::MAX63)
                        begin
                            ovl_reg <= coa_pkg::MAX63[62:0];
                        end
                        else
                        begin
                            ovl_reg <= q_reg[62:0];
                        end
                    end
                    coa_pkg::DJ_PD1:
                    begin
                        if (den_reg == '0)
                        begin
                            pd1_reg <= (pk1_reg == '0) ? '0 : coa_pkg::MAX32;
                        end
                        else
                        begin
                            pd1_reg <= (qovf_reg || q_reg[63:32] != '0) ? coa_pkg::MAX32
                                                                       : q_reg[31:0];
                        end
                    end
                    default:
                    begin
                        if (den_reg == '0)
                        begin
                            pd2_reg <= (pk2_reg == '0) ? '0 : coa_pkg::MAX32;
                        end
                        else
                        begin
                            pd2_reg <= (qovf_reg || q_reg[63:32] != '0) ? coa_pkg::MAX32
                                                                       : q_reg[31:0];
                        end
                    end
                endcase
            end
            coa_pkg::OP_PUBLISH:
            begin
                overlap_value       <= ovl_reg;
                inner_real          <= ore_reg;
                inner_imag          <= oim_reg;
                norm_first          <= n1_reg;
                norm_second         <= n2_reg;
                peak_density_first  <= pd1_reg;
                peak_density_second <= pd2_reg;
            end
            default:
            begin
            end
        endcase
    end

endmodule

// ===== hdl/complex_overlap_accumulator.sv =====
// ----------------------------------------------------------------------------
// complex_overlap_accumulator
// Complex inner product, norms and peak densities over a grid, with overlap.
// ----------------------------------------------------------------------------
// Usage:
//   samples: one grid point per item, four Q1.15 parts and last_point.
//   Items are taken one per cycle while the block accumulates.
//   results: one item per data set, after the item marked last_point.
//   After the last item the block passes a drain state, then the shared 32x32
//   multiplier forms seven 64-bit products, the square root unit runs and the
//   radix-2 divider forms three quotients; a publish step then loads the
//   output register and raises results.valid.
//   No sample is taken from the last item until the result is published.
//   The result sits in an output register; if the receiver stalls, the
//   publish waits until the previous result is taken.
//   cell_volume sits at APB address 0, unsigned Q16.16; write it only idle.
//   Reset clears the accumulators, the controller and results.valid, and
//   sets cell_volume to 1.0.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module complex_overlap_accumulator (
    input  logic        clk,
    input  logic        rst_n,
    coa_in_if.sink      samples,
    coa_out_if.source   results,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    logic [31:0]   cell_volume_reg;
    coa_pkg::cmd_t cmd;
    logic          in_fire;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cell_volume_reg <= coa_pkg::CELL_VOLUME_RESET;
        end
        else if (psel && penable && pwrite && paddr[2] == coa_pkg::ADDR_CELL_VOLUME)
        begin
            cell_volume_reg <= pwdata;
        end
    end

    assign pready  = 1'b1;
    assign prdata  = (paddr[2] == coa_pkg::ADDR_CELL_VOLUME) ? cell_volume_reg : '0;
    assign in_fire = samples.valid && samples.ready;

    coa_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (samples.valid),
        .in_last   (samples.last_point),
        .in_ready  (samples.ready),
        .out_valid (results.valid),
        .out_ready (results.ready),
        .cmd       (cmd)
    );

    coa_datapath u_datapath (
        .clk                 (clk),
        .rst_n               (rst_n),
        .in_fire             (in_fire),
        .first_real          (samples.first_real),
        .first_imag          (samples.first_imag),
        .second_real         (samples.second_real),
        .second_imag         (samples.second_imag),
        .cell_volume         (cell_volume_reg),
        .cmd                 (cmd),
        .overlap_value       (results.overlap_value),
        .inner_real          (results.inner_real),
        .inner_imag          (results.inner_imag),
        .norm_first          (results.norm_first),
        .norm_second         (results.norm_second),
        .peak_density_first  (results.peak_density_first),
        .peak_density_second (results.peak_density_second)
    );

    `COA_ASSERT_NEXT(a_stop_after_last, in_fire && samples.last_point, !samples.ready)
    `COA_ASSERT_SAME(a_idle_when_taking, samples.ready, cmd.op == coa_pkg::OP_IDLE)
    `COA_ASSERT_NEXT(a_publish_shows, cmd.op == coa_pkg::OP_PUBLISH, results.valid)
    `COA_ASSERT_NEXT(a_taken_drops,
        results.valid && results.ready && cmd.op != coa_pkg::OP_PUBLISH, !results.valid)

endmodule
